// File: hdl/bsab_pkg.sv
// shared types, mode codes and the channel lerp for the sample and blend pipeline
package bsab_pkg;

   typedef logic [7:0]       chan_type;
   typedef chan_type [3:0]   pixel_type;
   typedef logic [8:0]       weight_type;

   localparam logic [2:0] MODE_NEAR_COPY  = 3'd0;
   localparam logic [2:0] MODE_NEAR_BLEND = 3'd1;
   localparam logic [2:0] MODE_BILIN_COPY = 3'd2;
   localparam logic [2:0] MODE_BILIN_BLEND = 3'd3;
   localparam logic [2:0] MODE_ADD        = 3'd4;
   localparam logic [2:0] MODE_ADD_OPA    = 3'd5;

   localparam chan_type OPACITY_RESET = 8'hFF;

   // a + ((b - a) * w) >> 8, all in 16-bit lanes, wrapping to 8 bits
   function automatic chan_type lerp8(input chan_type a, input chan_type b,
                                      input weight_type w);
      logic [15:0] diff;
      logic [15:0] prod;
      diff = {8'h00, b} - {8'h00, a};
      prod = 16'(diff * {7'b0, w});
      return 8'(a + prod[15:8]);
   endfunction

endpackage

// File: hdl/bilinear_sample_alpha_blend.sv
// five-stage pipeline: nearest or bilinear texel sample, constant-opacity and additive blend
// an accepted request moves through the stage registers in order and shows on rsp_valid from the output register
// throughput: one request per cycle while rsp_ready keeps the pipe moving
// stalls back up stage by stage through the ready chain, nothing lost or repeated
// reset (synchronous, active high) clears all stage valid bits and sets opacity to 255
// payload registers are not reset
module bilinear_sample_alpha_blend (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_x_frac,
   input  logic [15:0] req_y_frac,
   input  logic [31:0] req_texel_top_left,
   input  logic [31:0] req_texel_top_right,
   input  logic [31:0] req_texel_bottom_left,
   input  logic [31:0] req_texel_bottom_right,
   input  logic [31:0] req_dest_pixel,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_pixel,
   // opacity register write
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   localparam int STAGES = 5;

   // opacity register, to be written only while the pipe is empty; the block itself does not enforce this
   bsab_pkg::chan_type   opacity_ff;
   bsab_pkg::weight_type opa2_w;

   // per-stage valid bits and ready chain
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] rdy_w;

   // stage 1: horizontal lerps and nearest results
   bsab_pkg::pixel_type  s1_top_ff, s1_top_in;
   bsab_pkg::pixel_type  s1_bot_ff, s1_bot_in;
   bsab_pkg::pixel_type  s1_pass_ff, s1_pass_in;
   bsab_pkg::pixel_type  s1_dest_ff;
   logic [2:0]           s1_mode_ff;
   bsab_pkg::weight_type s1_wy_ff, s1_wy_in;

   // stage 2: vertical lerp
   bsab_pkg::pixel_type  s2_samp_ff, s2_samp_in;
   bsab_pkg::pixel_type  s2_pass_ff;
   bsab_pkg::pixel_type  s2_dest_ff;
   logic [2:0]           s2_mode_ff;

   // stage 3: opacity scaling and bilinear blend
   bsab_pkg::pixel_type  s3_src_ff, s3_src_in;
   bsab_pkg::pixel_type  s3_res_ff, s3_res_in;
   bsab_pkg::pixel_type  s3_dest_ff;
   logic                 s3_add_ff, s3_add_in;

   // stage 4: destination scaled by sample alpha
   bsab_pkg::pixel_type  s4_dscale_ff, s4_dscale_in;
   bsab_pkg::pixel_type  s4_src_ff;
   bsab_pkg::pixel_type  s4_res_ff;
   bsab_pkg::pixel_type  s4_dest_ff;
   logic                 s4_add_ff;

   // stage 5: output register
   bsab_pkg::pixel_type  s5_out_ff, s5_out_in;

   // input views as channel arrays
   bsab_pkg::pixel_type  tl_w, tr_w, bl_w, br_w, dp_w;
   bsab_pkg::weight_type wx_w;

   assign tl_w = req_texel_top_left;
   assign tr_w = req_texel_top_right;
   assign bl_w = req_texel_bottom_left;
   assign br_w = req_texel_bottom_right;
   assign dp_w = req_dest_pixel;

   // x weight 0..255, y weight 0..256, blend opacity 0..256
   assign wx_w     = {1'b0, req_x_frac[15:8]};
   assign s1_wy_in = {1'b0, req_y_frac[15:8]} + 9'(req_y_frac[15]);
   assign opa2_w   = {1'b0, opacity_ff} + 9'(opacity_ff[7]);

   // a stage takes new data when it is empty or its content moves on
   always_comb begin
      rdy_w[STAGES-1] = !vld_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy_w[k] = !vld_ff[k] || rdy_w[k+1];
      end
      vld_in[0] = req_valid;
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign req_ready     = rdy_w[0];
   assign rsp_valid     = vld_ff[STAGES-1];
   assign rsp_out_pixel = s5_out_ff;

   // stage 1 logic: top and bottom row lerps, nearest copy or blend
   always_comb begin
      bsab_pkg::pixel_type near;
      for (int k = 0; k < 4; k++) begin
         s1_top_in[k] = bsab_pkg::lerp8(tl_w[k], tr_w[k], wx_w);
         s1_bot_in[k] = bsab_pkg::lerp8(bl_w[k], br_w[k], wx_w);
         near[k]      = bsab_pkg::lerp8(dp_w[k], tl_w[k], {1'b0, opacity_ff});
      end
      unique case (req_mode)
         bsab_pkg::MODE_NEAR_COPY:  s1_pass_in = tl_w;
         bsab_pkg::MODE_NEAR_BLEND: s1_pass_in = near;
         default:                   s1_pass_in = dp_w;
      endcase
   end

   // stage 2 logic: vertical lerp
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         s2_samp_in[k] = bsab_pkg::lerp8(s1_top_ff[k], s1_bot_ff[k], s1_wy_ff);
      end
   end

   // stage 3 logic: scale the sample for additive with opacity, blend for mode 3
   always_comb begin
      bsab_pkg::pixel_type scaled;
      bsab_pkg::pixel_type blend;
      logic [15:0]         prod;
      for (int k = 0; k < 4; k++) begin
         prod      = 16'({8'h00, s2_samp_ff[k]} * {7'b0, opa2_w});
         scaled[k] = prod[15:8];
         blend[k]  = bsab_pkg::lerp8(s2_dest_ff[k], s2_samp_ff[k], opa2_w);
      end
      s3_src_in = (s2_mode_ff == bsab_pkg::MODE_ADD_OPA) ? scaled : s2_samp_ff;
      s3_add_in = (s2_mode_ff == bsab_pkg::MODE_ADD) ||
                  (s2_mode_ff == bsab_pkg::MODE_ADD_OPA);
      unique case (s2_mode_ff)
         bsab_pkg::MODE_BILIN_COPY:  s3_res_in = s2_samp_ff;
         bsab_pkg::MODE_BILIN_BLEND: s3_res_in = blend;
         default:                    s3_res_in = s2_pass_ff;
      endcase
   end

   // stage 4 logic: (d * source alpha) >> 8 per channel
   always_comb begin
      logic [15:0] prod;
      for (int k = 0; k < 4; k++) begin
         prod            = 16'({8'h00, s3_dest_ff[k]} * {8'h00, s3_src_ff[3]});
         s4_dscale_in[k] = prod[15:8];
      end
   end

   // stage 5 logic: saturating additive sum or the pass-through result
   always_comb begin
      logic [9:0] sum;
      for (int k = 0; k < 4; k++) begin
         sum = {2'b00, s4_src_ff[k]} + {2'b00, s4_dest_ff[k]} - {2'b00, s4_dscale_ff[k]};
         if (!s4_add_ff) begin
            s5_out_in[k] = s4_res_ff[k];
         end else if (sum > 10'd255) begin
            s5_out_in[k] = 8'hFF;
         end else begin
            s5_out_in[k] = sum[7:0];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         opacity_ff <= bsab_pkg::OPACITY_RESET;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (rdy_w[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
         if (csr_write_enable) begin
            opacity_ff <= csr_write_data;
         end
      end
   end

   // payload registers, each stage loads when it may take new data
   always_ff @(posedge clock) begin
      if (rdy_w[0]) begin
         s1_top_ff  <= s1_top_in;
         s1_bot_ff  <= s1_bot_in;
         s1_pass_ff <= s1_pass_in;
         s1_dest_ff <= dp_w;
         s1_mode_ff <= req_mode;
         s1_wy_ff   <= s1_wy_in;
      end
      if (rdy_w[1]) begin
         s2_samp_ff <= s2_samp_in;
         s2_pass_ff <= s1_pass_ff;
         s2_dest_ff <= s1_dest_ff;
         s2_mode_ff <= s1_mode_ff;
      end
      if (rdy_w[2]) begin
         s3_src_ff  <= s3_src_in;
         s3_res_ff  <= s3_res_in;
         s3_dest_ff <= s2_dest_ff;
         s3_add_ff  <= s3_add_in;
      end
      if (rdy_w[3]) begin
         s4_dscale_ff <= s4_dscale_in;
         s4_src_ff    <= s3_src_ff;
         s4_res_ff    <= s3_res_ff;
         s4_dest_ff   <= s3_dest_ff;
         s4_add_ff    <= s3_add_ff;
      end
      if (rdy_w[4]) begin
         s5_out_ff <= s5_out_in;
      end
   end

`ifndef ASSERT_OFF
   // any empty stage lets the ready chain reach the request side
   a_ready_when_not_full: assert property (@(posedge clock) disable iff (reset)
      !(&vld_ff) |-> req_ready)
      else $error("request stalled with a bubble in the pipe");

   // a held stage 3 keeps its request and payload
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && !rdy_w[3]) |=> (vld_ff[2] && $stable(s3_src_ff) && $stable(s3_res_ff)))
      else $error("stalled request lost or changed in stage 3");

   // a stalled result keeps its pixel
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(s5_out_ff))
      else $error("output register changed under stall");

   // opacity comes out of reset fully opaque
   a_opacity_reset: assert property (@(posedge clock)
      reset |=> (opacity_ff == bsab_pkg::OPACITY_RESET))
      else $error("opacity not restored by reset");
`endif

endmodule

// File: bench/blend_checker.sv
// request/response monitor for the sample and blend pipeline with its own pixel predictor
module blend_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_x_frac,
   input  logic [15:0] req_y_frac,
   input  logic [31:0] req_texel_top_left,
   input  logic [31:0] req_texel_top_right,
   input  logic [31:0] req_texel_bottom_left,
   input  logic [31:0] req_texel_bottom_right,
   input  logic [31:0] req_dest_pixel,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_out_pixel,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   output int          failures,
   output int          pending,
   output int          pixels_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   bsab_pkg::pixel_type expected_pixels[$];
   bsab_pkg::chan_type  opacity_shadow;
   int                  mismatch_count;
   int                  compare_count;

   // one channel step toward b by w/256, 16-bit lanes, wraps to 8 bits
   function automatic bsab_pkg::chan_type mix_channel(input bsab_pkg::chan_type a,
                                                      input bsab_pkg::chan_type b,
                                                      input bsab_pkg::weight_type w);
      logic [15:0] span;
      logic [31:0] scaled;
      span   = {8'h00, b} - {8'h00, a};
      scaled = {16'h0000, span} * {23'h0, w};
      return a + scaled[15:8];
   endfunction

   function automatic bsab_pkg::pixel_type predict_blend(input logic [2:0] mode,
                                               input logic [15:0] x_frac,
                                               input logic [15:0] y_frac,
                                               input bsab_pkg::pixel_type tl,
                                               input bsab_pkg::pixel_type tr,
                                               input bsab_pkg::pixel_type bl,
                                               input bsab_pkg::pixel_type br,
                                               input bsab_pkg::pixel_type dest,
                                               input bsab_pkg::chan_type opacity);
      bsab_pkg::weight_type wx;
      bsab_pkg::weight_type wy;
      bsab_pkg::weight_type opa_wide;
      bsab_pkg::pixel_type  sample;
      bsab_pkg::pixel_type  result;
      bsab_pkg::chan_type   top_row;
      bsab_pkg::chan_type   bot_row;
      logic [16:0] scaled;
      logic [15:0] diff;
      logic [31:0] acc;
      logic [15:0] dest_alpha;
      logic [9:0]  sum;
      int          k;
      wx       = {1'b0, x_frac[15:8]};
      wy       = {1'b0, y_frac[15:8]} + 9'(y_frac[15]);
      opa_wide = {1'b0, opacity} + 9'(opacity[7]);
      for (k = 0; k < 4; k++) begin
         top_row   = mix_channel(tl[k], tr[k], wx);
         bot_row   = mix_channel(bl[k], br[k], wx);
         sample[k] = mix_channel(top_row, bot_row, wy);
      end
      if (mode == bsab_pkg::MODE_ADD_OPA) begin
         for (k = 0; k < 4; k++) begin
            scaled    = {9'h000, sample[k]} * {8'h00, opa_wide};
            sample[k] = scaled[15:8];
         end
      end
      for (k = 0; k < 4; k++) begin
         case (mode)
            bsab_pkg::MODE_NEAR_COPY: result[k] = tl[k];
            bsab_pkg::MODE_NEAR_BLEND: begin
               diff      = {8'h00, tl[k]} - {8'h00, dest[k]};
               acc       = {16'h0000, dest[k], 8'h00} + {16'h0000, diff} * {24'h0, opacity};
               result[k] = acc[15:8];
            end
            bsab_pkg::MODE_BILIN_COPY: result[k] = sample[k];
            bsab_pkg::MODE_BILIN_BLEND: result[k] = mix_channel(dest[k], sample[k], opa_wide);
            bsab_pkg::MODE_ADD, bsab_pkg::MODE_ADD_OPA: begin
               dest_alpha = {8'h00, dest[k]} * {8'h00, sample[3]};
               sum        = {2'b00, sample[k]} + {2'b00, dest[k]} - {2'b00, dest_alpha[15:8]};
               result[k]  = (sum > 10'd255) ? 8'hFF : sum[7:0];
            end
            default: result[k] = dest[k];
         endcase
      end
      return result;
   endfunction

   always @(posedge clock) begin
      bsab_pkg::pixel_type want;
      if (reset) begin
         expected_pixels.delete();
         opacity_shadow = bsab_pkg::OPACITY_RESET;
         mismatch_count = 0;
         compare_count  = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_pixels.push_back(predict_blend(req_mode, req_x_frac, req_y_frac,
                                                    req_texel_top_left, req_texel_top_right,
                                                    req_texel_bottom_left,
                                                    req_texel_bottom_right,
                                                    req_dest_pixel, opacity_shadow));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("out_pixel %08h arrived with no request outstanding", rsp_out_pixel);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               compare_count++;
               if (rsp_out_pixel !== want) begin
                  $error("out_pixel mismatch: expected %08h, actual %08h",
                         want, rsp_out_pixel);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable)
            opacity_shadow = csr_write_data;
      end
      failures       <= mismatch_count;
      pending        <= expected_pixels.size();
      pixels_checked <= compare_count;
   end

endmodule

// File: bench/tb.sv
// top of the bench: request stimulus, response backpressure, opacity phases and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES    = 9;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 165;
   // extra wait after the last outstanding pixel has been compared
   localparam int DRAIN_CYCLES    = 12;
   localparam int TIMEOUT_CYCLES  = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = '0;
   logic [15:0] req_x_frac = '0;
   logic [15:0] req_y_frac = '0;
   logic [31:0] req_texel_top_left = '0;
   logic [31:0] req_texel_top_right = '0;
   logic [31:0] req_texel_bottom_left = '0;
   logic [31:0] req_texel_bottom_right = '0;
   logic [31:0] req_dest_pixel = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_out_pixel;

   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = '0;

   int          failures;
   int          pending;
   int          pixels_checked;

   // sender burst bookkeeping
   int          burst_left = 1;
   int          requests_sent = 0;
   int          directed_sent = 0;
   int          opacity_writes = 0;

   // receiver backpressure: a rotating 16-bit ready pattern, reshuffled now and then
   logic [15:0] ready_pattern = 16'hFFFF;
   int          pattern_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bilinear_sample_alpha_blend u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode               (req_mode),
      .req_x_frac             (req_x_frac),
      .req_y_frac             (req_y_frac),
      .req_texel_top_left     (req_texel_top_left),
      .req_texel_top_right    (req_texel_top_right),
      .req_texel_bottom_left  (req_texel_bottom_left),
      .req_texel_bottom_right (req_texel_bottom_right),
      .req_dest_pixel         (req_dest_pixel),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_out_pixel          (rsp_out_pixel),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data)
   );

   blend_checker u_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_mode               (req_mode),
      .req_x_frac             (req_x_frac),
      .req_y_frac             (req_y_frac),
      .req_texel_top_left     (req_texel_top_left),
      .req_texel_top_right    (req_texel_top_right),
      .req_texel_bottom_left  (req_texel_bottom_left),
      .req_texel_bottom_right (req_texel_bottom_right),
      .req_dest_pixel         (req_dest_pixel),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_out_pixel          (rsp_out_pixel),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data),
      .failures               (failures),
      .pending                (pending),
      .pixels_checked         (pixels_checked)
   );

   // ready pattern never goes all-zero, about a quarter of the stretches run without stalls
   always @(posedge clock) begin
      if (pattern_left == 0) begin
         pattern_left  <= $urandom_range(40, 300);
         ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                      : (16'($urandom()) | 16'h0001);
      end else begin
         pattern_left  <= pattern_left - 1;
         ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
      rsp_ready <= ready_pattern[0];
   end

   // present one request, hold it until accepted, then maybe close the burst with a gap
   task automatic push_request(input logic [2:0] mode, input logic [15:0] x_frac,
                               input logic [15:0] y_frac, input logic [31:0] tl,
                               input logic [31:0] tr, input logic [31:0] bl,
                               input logic [31:0] br, input logic [31:0] dest);
      int gap;
      req_valid              <= 1'b1;
      req_mode               <= mode;
      req_x_frac             <= x_frac;
      req_y_frac             <= y_frac;
      req_texel_top_left     <= tl;
      req_texel_top_right    <= tr;
      req_texel_bottom_left  <= bl;
      req_texel_bottom_right <= br;
      req_dest_pixel         <= dest;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 48);
         gap        = $urandom_range(0, 5);
         // zero gap keeps valid high straight into the next burst
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop sending and wait for every outstanding pixel, plus a further DRAIN_CYCLES wait
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // opacity only changes with the pipeline empty
   task automatic write_opacity(input bsab_pkg::chan_type value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      opacity_writes++;
   endtask

   // fraction mix: the weight extremes and the y-weight carry point show up often
   function automatic logic [15:0] pick_frac();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         3:       return 16'h7FFF;
         default: return 16'($urandom());
      endcase
   endfunction

   // texels: solid extremes, per-channel extremes, or plain random
   function automatic logic [31:0] pick_texel();
      logic [31:0] px;
      int          k;
      case ($urandom_range(0, 5))
         0: px = 32'h0000_0000;
         1: px = 32'hFFFF_FFFF;
         2: begin
            for (k = 0; k < 4; k++) begin
               case ($urandom_range(0, 2))
                  0:       px[8*k +: 8] = 8'h00;
                  1:       px[8*k +: 8] = 8'hFF;
                  default: px[8*k +: 8] = 8'($urandom());
               endcase
            end
         end
         default: px = $urandom();
      endcase
      return px;
   endfunction

   // unused mode codes still appear, about one request in sixteen
   function automatic logic [2:0] pick_mode();
      if ($urandom_range(0, 15) == 0)
         return 3'($urandom_range(6, 7));
      return 3'($urandom_range(0, 5));
   endfunction

   task automatic push_random_request();
      push_request(pick_mode(), pick_frac(), pick_frac(), pick_texel(), pick_texel(),
                   pick_texel(), pick_texel(), pick_texel());
   endtask

   // opacity per phase: both ends and their neighbours, the rounding step at 128, then random values
   function automatic bsab_pkg::chan_type phase_opacity(input int phase);
      case (phase)
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         4:       return 8'h01;
         5:       return 8'hFE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic run_directed();
      int i;
      // every mode code at full weights: lerps with b below a wrap, y weight reaches 256
      for (i = 0; i < 8; i++)
         push_request(3'(i), 16'hFFFF, 16'hFFFF, 32'h0000_0000, '1, '1, '1, '1);
      // every mode code at zero weights, only the top-left texel matters
      for (i = 0; i < 8; i++)
         push_request(3'(i), 16'h0000, 16'h0000, '1, '0, '0, '0, '0);
      // additive saturation, plain and opacity-scaled
      push_request(bsab_pkg::MODE_ADD, 16'h40C0, 16'hC040, '1, '1, '1, '1, 32'h8080_8080);
      push_request(bsab_pkg::MODE_ADD_OPA, 16'h40C0, 16'hC040, '1, '1, '1, '1,
                   32'h8080_8080);
      // y weight just past the carry, x low byte ignored
      push_request(bsab_pkg::MODE_BILIN_COPY, 16'h80FF, 16'h8000, 32'h10E0_7F01,
                   32'hE010_01FE, 32'h00FF_8040, 32'hFF00_4080, 32'h5A5A_A5A5);
      // y weight just below the carry
      push_request(bsab_pkg::MODE_BILIN_BLEND, 16'h00FF, 16'h7FFF, 32'h01FE_807F,
                   32'hFE01_7F80, 32'hFF00_00FF, 32'h00FF_FF00, 32'hA5A5_5A5A);
      // nearest blend with source both above and below the destination
      push_request(bsab_pkg::MODE_NEAR_BLEND, 16'h1234, 16'h5678, 32'h00FF_8001,
                   32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'hFF00_0180);
      directed_sent = requests_sent;
   endtask

   initial begin
      int phase;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed part under the reset opacity, written explicitly
      write_opacity(bsab_pkg::OPACITY_RESET);
      run_directed();
      quiesce();
      for (phase = 0; phase < PHASES; phase++) begin
         write_opacity(phase_opacity(phase));
         repeat (ITEMS_PER_PHASE) push_random_request();
         quiesce();
      end
      $display("covered %0d requests (%0d directed) over %0d opacity settings, all modes",
               requests_sent, directed_sent, opacity_writes);
      $display("compared %0d output pixels, %0d mismatches", pixels_checked, failures);
      if (failures == 0) begin
         $display("PASS bilinear_sample_alpha_blend");
      end else begin
         $display("FAIL bilinear_sample_alpha_blend");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("FAIL bilinear_sample_alpha_blend");
      $finish;
   end

endmodule
